@@ rtl/dtc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtc_pkg
// Shared constants and types of the degenerate triangle check pipeline.
// ----------------------------------------------------------------------------
package dtc_pkg;

   // default coordinate width and area tolerance shift
   localparam int COORD_BITS_DEF = 16;
   localparam int EPS_SHIFT_DEF  = 52;

   // index and vertex count widths are fixed by the interface
   localparam int INDEX_BITS = 16;
   localparam int COUNT_BITS = 17;

   // control flags that travel down the pipeline with each word
   typedef struct packed {
      logic valid;
      logic out_of_range;
      logic repeated_index;
   } flags_type;

endpackage
`default_nettype wire

@@ rtl/dtc_mul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtc_mul
// Two-stage unsigned multiplier: operands split into halves, four partial
// products registered, then summed into the full product.
// ----------------------------------------------------------------------------
module dtc_mul #(
   parameter int W = 34
) (
   input  logic             clock,
   input  logic             en,
   input  logic [W-1:0]     op_a,
   input  logic [W-1:0]     op_b,
   output logic [2*W-1:0]   product
);

   localparam int LO = (W + 1) / 2;
   localparam int HI = W - LO;

   logic [2*LO-1:0]     ll_in, ll_ff;
   logic [W-1:0]        lh_in, lh_ff;
   logic [W-1:0]        hl_in, hl_ff;
   logic [2*HI-1:0]     hh_in, hh_ff;
   logic [W:0]          mid_sum;
   logic [2*W-1:0]      mid_ext;
   logic [2*W-1:0]      product_in, product_ff;

   // form the partial products of the operand halves
   always_comb begin
      ll_in = op_a[LO-1:0] * op_b[LO-1:0];
      lh_in = op_a[LO-1:0] * op_b[W-1:LO];
      hl_in = op_a[W-1:LO] * op_b[LO-1:0];
      hh_in = op_a[W-1:LO] * op_b[W-1:LO];
   end

   // combine the registered partial products
   always_comb begin
      mid_sum    = {1'b0, lh_ff} + {1'b0, hl_ff};
      mid_ext    = {{(W-1){1'b0}}, mid_sum};
      product_in = {hh_ff, ll_ff} + (mid_ext << LO);
   end

   // advance both stages together
   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff      <= ll_in;
         lh_ff      <= lh_in;
         hl_ff      <= hl_in;
         hh_ff      <= hh_in;
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule
`default_nettype wire

@@ rtl/dtc_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtc_front
// First three pipeline stages: index checks and edge vectors, the cross and
// self products of the edges, then cross magnitudes and squared edge lengths.
// ----------------------------------------------------------------------------
module dtc_front #(
   parameter int COORD_BITS = dtc_pkg::COORD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic [dtc_pkg::INDEX_BITS-1:0]      index_a,
   input  logic [dtc_pkg::INDEX_BITS-1:0]      index_b,
   input  logic [dtc_pkg::INDEX_BITS-1:0]      index_c,
   input  logic [dtc_pkg::COUNT_BITS-1:0]      vertex_count,
   input  logic signed [COORD_BITS-1:0]        pos_a [3],
   input  logic signed [COORD_BITS-1:0]        pos_b [3],
   input  logic signed [COORD_BITS-1:0]        pos_c [3],
   output dtc_pkg::flags_type                  flags,
   output logic [2*COORD_BITS+1:0]             cross_mag [3],
   output logic [2*COORD_BITS+2:0]             edge_ab,
   output logic [2*COORD_BITS+2:0]             edge_ac
);

   localparam int DW  = COORD_BITS + 1;     // edge component
   localparam int PW  = 2 * DW;             // signed product
   localparam int XW  = PW + 1;             // cross component
   localparam int MW  = XW - 1;             // cross magnitude
   localparam int SQW = 2 * COORD_BITS + 1; // squared edge component
   localparam int LW  = SQW + 2;            // squared edge length

   dtc_pkg::flags_type        s1_flags_in, s1_flags_ff, s2_flags_ff, s3_flags_ff;
   logic signed [DW-1:0]      s1_ab_in [3];
   logic signed [DW-1:0]      s1_ac_in [3];
   logic signed [DW-1:0]      s1_ab_ff [3];
   logic signed [DW-1:0]      s1_ac_ff [3];
   logic signed [PW-1:0]      s2_pos_in [3];
   logic signed [PW-1:0]      s2_neg_in [3];
   logic signed [PW-1:0]      s2_pos_ff [3];
   logic signed [PW-1:0]      s2_neg_ff [3];
   logic signed [PW-1:0]      sq_ab_full [3];
   logic signed [PW-1:0]      sq_ac_full [3];
   logic [SQW-1:0]            s2_sq_ab_ff [3];
   logic [SQW-1:0]            s2_sq_ac_ff [3];
   logic signed [XW-1:0]      cross_full [3];
   logic [XW-1:0]             cross_abs [3];
   logic [MW-1:0]             s3_mag_in [3];
   logic [MW-1:0]             s3_mag_ff [3];
   logic [LW-1:0]             s3_eab_in, s3_eab_ff;
   logic [LW-1:0]             s3_eac_in, s3_eac_ff;
   logic                      in_range;

   // stage 1: range and repeat checks, edge vectors
   always_comb begin
      in_range = ({1'b0, index_a} < vertex_count) && ({1'b0, index_b} < vertex_count) &&
                 ({1'b0, index_c} < vertex_count);
      s1_flags_in.valid          = in_valid;
      s1_flags_in.out_of_range   = !in_range;
      s1_flags_in.repeated_index = in_range &&
                                   ((index_a == index_b) || (index_b == index_c) ||
                                    (index_a == index_c));
      for (int k = 0; k < 3; k++) begin
         s1_ab_in[k] = {pos_b[k][COORD_BITS-1], pos_b[k]} - {pos_a[k][COORD_BITS-1], pos_a[k]};
         s1_ac_in[k] = {pos_c[k][COORD_BITS-1], pos_c[k]} - {pos_a[k][COORD_BITS-1], pos_a[k]};
      end
   end

   // stage 2: cross product terms and squared components
   always_comb begin
      s2_pos_in[0] = s1_ab_ff[1] * s1_ac_ff[2];
      s2_neg_in[0] = s1_ab_ff[2] * s1_ac_ff[1];
      s2_pos_in[1] = s1_ab_ff[2] * s1_ac_ff[0];
      s2_neg_in[1] = s1_ab_ff[0] * s1_ac_ff[2];
      s2_pos_in[2] = s1_ab_ff[0] * s1_ac_ff[1];
      s2_neg_in[2] = s1_ab_ff[1] * s1_ac_ff[0];
      for (int k = 0; k < 3; k++) begin
         sq_ab_full[k] = s1_ab_ff[k] * s1_ab_ff[k];
         sq_ac_full[k] = s1_ac_ff[k] * s1_ac_ff[k];
      end
   end

   // stage 3: cross components as magnitudes, squared edge lengths
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cross_full[k] = {s2_pos_ff[k][PW-1], s2_pos_ff[k]} -
                         {s2_neg_ff[k][PW-1], s2_neg_ff[k]};
         cross_abs[k]  = cross_full[k][XW-1] ? (~cross_full[k] + XW'(1)) : cross_full[k];
         s3_mag_in[k]  = cross_abs[k][MW-1:0];
      end
      s3_eab_in = LW'(s2_sq_ab_ff[0]) + LW'(s2_sq_ab_ff[1]) + LW'(s2_sq_ab_ff[2]);
      s3_eac_in = LW'(s2_sq_ac_ff[0]) + LW'(s2_sq_ac_ff[1]) + LW'(s2_sq_ac_ff[2]);
   end

   // advance the control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_flags_ff <= '0;
         s2_flags_ff <= '0;
         s3_flags_ff <= '0;
      end else if (en) begin
         s1_flags_ff <= s1_flags_in;
         s2_flags_ff <= s1_flags_ff;
         s3_flags_ff <= s2_flags_ff;
      end
   end

   // advance the arithmetic
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            s1_ab_ff[k]    <= s1_ab_in[k];
            s1_ac_ff[k]    <= s1_ac_in[k];
            s2_pos_ff[k]   <= s2_pos_in[k];
            s2_neg_ff[k]   <= s2_neg_in[k];
            s2_sq_ab_ff[k] <= sq_ab_full[k][SQW-1:0];
            s2_sq_ac_ff[k] <= sq_ac_full[k][SQW-1:0];
            s3_mag_ff[k]   <= s3_mag_in[k];
         end
         s3_eab_ff <= s3_eab_in;
         s3_eac_ff <= s3_eac_in;
      end
   end

   assign flags        = s3_flags_ff;
   assign cross_mag[0] = s3_mag_ff[0];
   assign cross_mag[1] = s3_mag_ff[1];
   assign cross_mag[2] = s3_mag_ff[2];
   assign edge_ab      = s3_eab_ff;
   assign edge_ac      = s3_eac_ff;

endmodule
`default_nettype wire

@@ rtl/dtc_tail.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtc_tail
// Last two stages: sum the squared cross components, then compare the scaled
// area against the edge product and register the result word.
// ----------------------------------------------------------------------------
module dtc_tail #(
   parameter int COORD_BITS = dtc_pkg::COORD_BITS_DEF,
   parameter int EPS_SHIFT  = dtc_pkg::EPS_SHIFT_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  dtc_pkg::flags_type         flags,
   input  logic [4*COORD_BITS+3:0]    cross_sq [3],
   input  logic [4*COORD_BITS+5:0]    edge_prod,
   output logic                       rsp_valid,
   output logic                       rsp_out_of_range,
   output logic                       rsp_repeated_index,
   output logic                       rsp_degenerate
);

   localparam int AW = 4 * COORD_BITS + 6;  // area sum and edge product
   localparam int TW = AW + EPS_SHIFT;      // scaled compare width

   dtc_pkg::flags_type   s6_flags_ff;
   logic [AW-1:0]        s6_area_in, s6_area_ff;
   logic [AW-1:0]        s6_edge_ff;
   logic [TW-1:0]        area_scaled;
   logic [TW-1:0]        edge_wide;
   logic                 thin;
   logic                 valid_ff;
   logic                 oor_ff, rep_ff, degen_ff;
   logic                 degen_in;

   // sum the squared cross components
   always_comb begin
      s6_area_in = AW'(cross_sq[0]) + AW'(cross_sq[1]) + AW'(cross_sq[2]);
   end

   // flag a thin triangle when the scaled area does not exceed the edge product
   always_comb begin
      area_scaled = TW'(s6_area_ff) << EPS_SHIFT;
      edge_wide   = TW'(s6_edge_ff);
      thin        = (area_scaled <= edge_wide);
      degen_in    = s6_flags_ff.repeated_index ||
                    (!s6_flags_ff.out_of_range && thin);
   end

   // clear the control flags on reset, else advance them
   always_ff @(posedge clock) begin
      if (reset) begin
         s6_flags_ff <= '0;
         valid_ff    <= 1'b0;
      end else if (en) begin
         s6_flags_ff <= flags;
         valid_ff    <= s6_flags_ff.valid;
      end
   end

   // advance the sum and the result word
   always_ff @(posedge clock) begin
      if (en) begin
         s6_area_ff <= s6_area_in;
         s6_edge_ff <= edge_prod;
         oor_ff     <= s6_flags_ff.out_of_range;
         rep_ff     <= s6_flags_ff.repeated_index;
         degen_ff   <= degen_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_out_of_range   = oor_ff;
   assign rsp_repeated_index = rep_ff;
   assign rsp_degenerate     = degen_ff;

endmodule
`default_nettype wire

@@ rtl/degenerate_triangle_check.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// degenerate_triangle_check
// Streams triangles and flags out-of-range indices, repeated indices and
// near-zero area against an exact integer tolerance.
// ----------------------------------------------------------------------------
// One triangle word is taken per clock unless the pipeline is frozen, and its
// result word passes through three front stages (index checks and edge vectors,
// cross and self products, cross magnitudes and edge lengths), two stages of
// split multipliers that square the cross components and multiply the squared
// edge lengths, one stage for the area sum and one for the final compare. The whole
// pipeline advances together and freezes only while a result word is held
// under rsp_stall. vertex_count resets to zero, so every triangle reads as
// out of range until it is written; write it only while the pipeline is empty.
module degenerate_triangle_check #(
   parameter int COORD_BITS = dtc_pkg::COORD_BITS_DEF,
   parameter int EPS_SHIFT  = dtc_pkg::EPS_SHIFT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dtc_pkg::COUNT_BITS-1:0]    csr_vertex_count,
   // triangle words
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [dtc_pkg::INDEX_BITS-1:0]    req_index_a,
   input  logic [dtc_pkg::INDEX_BITS-1:0]    req_index_b,
   input  logic [dtc_pkg::INDEX_BITS-1:0]    req_index_c,
   input  logic signed [COORD_BITS-1:0]      req_ax,
   input  logic signed [COORD_BITS-1:0]      req_ay,
   input  logic signed [COORD_BITS-1:0]      req_az,
   input  logic signed [COORD_BITS-1:0]      req_bx,
   input  logic signed [COORD_BITS-1:0]      req_by,
   input  logic signed [COORD_BITS-1:0]      req_bz,
   input  logic signed [COORD_BITS-1:0]      req_cx,
   input  logic signed [COORD_BITS-1:0]      req_cy,
   input  logic signed [COORD_BITS-1:0]      req_cz,
   // result words
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_out_of_range,
   output logic                              rsp_repeated_index,
   output logic                              rsp_degenerate
);

   localparam int MW = 2 * COORD_BITS + 2;  // cross magnitude
   localparam int LW = 2 * COORD_BITS + 3;  // squared edge length

   logic [dtc_pkg::COUNT_BITS-1:0]  count_ff;
   logic                            advance;
   logic signed [COORD_BITS-1:0]    pos_a [3];
   logic signed [COORD_BITS-1:0]    pos_b [3];
   logic signed [COORD_BITS-1:0]    pos_c [3];
   dtc_pkg::flags_type              front_flags;
   dtc_pkg::flags_type              m1_flags_ff, m2_flags_ff;
   logic [MW-1:0]                   cross_mag [3];
   logic [2*MW-1:0]                 cross_sq [3];
   logic [LW-1:0]                   edge_ab, edge_ac;
   logic [2*LW-1:0]                 edge_prod;

   // configuration is always taken
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_valid) begin
         count_ff <= csr_vertex_count;
      end
   end

   // freeze the whole pipeline while a result word is held
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   assign pos_a[0] = req_ax;
   assign pos_a[1] = req_ay;
   assign pos_a[2] = req_az;
   assign pos_b[0] = req_bx;
   assign pos_b[1] = req_by;
   assign pos_b[2] = req_bz;
   assign pos_c[0] = req_cx;
   assign pos_c[1] = req_cy;
   assign pos_c[2] = req_cz;

   dtc_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .en           (advance),
      .in_valid     (req_valid),
      .index_a      (req_index_a),
      .index_b      (req_index_b),
      .index_c      (req_index_c),
      .vertex_count (count_ff),
      .pos_a        (pos_a),
      .pos_b        (pos_b),
      .pos_c        (pos_c),
      .flags        (front_flags),
      .cross_mag    (cross_mag),
      .edge_ab      (edge_ab),
      .edge_ac      (edge_ac)
   );

   // square each cross component
   for (genvar k = 0; k < 3; k++) begin : g_cross_sq
      dtc_mul #(
         .W (MW)
      ) u_sq (
         .clock   (clock),
         .en      (advance),
         .op_a    (cross_mag[k]),
         .op_b    (cross_mag[k]),
         .product (cross_sq[k])
      );
   end

   // multiply the squared edge lengths
   dtc_mul #(
      .W (LW)
   ) u_edge_mul (
      .clock   (clock),
      .en      (advance),
      .op_a    (edge_ab),
      .op_b    (edge_ac),
      .product (edge_prod)
   );

   // carry the flags alongside the multipliers
   always_ff @(posedge clock) begin
      if (reset) begin
         m1_flags_ff <= '0;
         m2_flags_ff <= '0;
      end else if (advance) begin
         m1_flags_ff <= front_flags;
         m2_flags_ff <= m1_flags_ff;
      end
   end

   dtc_tail #(
      .COORD_BITS (COORD_BITS),
      .EPS_SHIFT  (EPS_SHIFT)
   ) u_tail (
      .clock              (clock),
      .reset              (reset),
      .en                 (advance),
      .flags              (m2_flags_ff),
      .cross_sq           (cross_sq),
      .edge_prod          (edge_prod),
      .rsp_valid          (rsp_valid),
      .rsp_out_of_range   (rsp_out_of_range),
      .rsp_repeated_index (rsp_repeated_index),
      .rsp_degenerate     (rsp_degenerate)
   );

`ifndef ASSERT_OFF
   // an out-of-range triangle carries no other flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> !rsp_repeated_index && !rsp_degenerate)
      else $error("out-of-range word carries a degeneracy flag");

   // a repeated index always marks the triangle degenerate
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_repeated_index |-> rsp_degenerate)
      else $error("repeated index without degenerate flag");

   // a held result word freezes the flags feeding the area-sum stage
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(m2_flags_ff))
      else $error("pipeline moved while the result word was held");
`endif

endmodule
`default_nettype wire
